// File: rtl/aidp_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer data-processing package
// Shared widths, group codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// -----------------------------------------------------------------------------
package aidp_pkg;

   localparam int unsigned XLEN      = 64;
   localparam int unsigned OP_W      = 4;
   localparam int unsigned INSTR_W   = 32;
   localparam int unsigned REG_AW    = 5;
   localparam int unsigned GPR_DEPTH = 32;
   localparam int unsigned NZCV_W    = 4;

   localparam logic [REG_AW-1:0] ZR_INDEX = 5'd31;

   // Instruction groups.
   localparam logic [OP_W-1:0] OP_ADDSUB_IMM = 4'd0;
   localparam logic [OP_W-1:0] OP_LOGIC_IMM  = 4'd1;
   localparam logic [OP_W-1:0] OP_MOVE_WIDE  = 4'd2;
   localparam logic [OP_W-1:0] OP_BITFIELD   = 4'd3;
   localparam logic [OP_W-1:0] OP_EXTRACT    = 4'd4;
   localparam logic [OP_W-1:0] OP_ONE_SRC    = 4'd5;
   localparam logic [OP_W-1:0] OP_TWO_SRC    = 4'd6;
   localparam logic [OP_W-1:0] OP_LOGIC_REG  = 4'd7;
   localparam logic [OP_W-1:0] OP_ADDSUB_REG = 4'd8;
   localparam logic [OP_W-1:0] OP_CARRY      = 4'd9;
   localparam logic [OP_W-1:0] OP_CONDSEL    = 4'd10;

   // One-source opcodes.
   localparam logic [5:0] OS_RBIT  = 6'd0;
   localparam logic [5:0] OS_REV16 = 6'd1;
   localparam logic [5:0] OS_REV32 = 6'd2;
   localparam logic [5:0] OS_REV64 = 6'd3;
   localparam logic [5:0] OS_CLZ   = 6'd4;
   localparam logic [5:0] OS_CLS   = 6'd5;

   // Two-source opcodes.
   localparam logic [5:0] TS_UDIV = 6'b000010;
   localparam logic [5:0] TS_SDIV = 6'b000011;
   localparam logic [5:0] TS_LSLV = 6'b001000;
   localparam logic [5:0] TS_LSRV = 6'b001001;
   localparam logic [5:0] TS_ASRV = 6'b001010;
   localparam logic [5:0] TS_RORV = 6'b001011;

   // Logical opcode that also sets the flags.
   localparam logic [1:0] LOGIC_ANDS = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_OPER,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } aidp_state_type;

   typedef struct packed {
      logic accept;
      logic load_ops;
      logic load_stage1;
      logic load_stage2;
      logic div_start;
      logic div_take;
      logic commit;
   } aidp_cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_done;
   } aidp_sts_type;

endpackage
`default_nettype wire

// File: rtl/aidp_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer data-processing channels
// Valid/ready channels for instruction beats and result beats.
// -----------------------------------------------------------------------------
interface aidp_req_if;
   import aidp_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [INSTR_W-1:0] instr_word;

   modport source (output valid, op, instr_word, input ready);
   modport sink   (input valid, op, instr_word, output ready);
endinterface

interface aidp_rsp_if;
   import aidp_pkg::*;

   logic              valid;
   logic              ready;
   logic              write_enable;
   logic [REG_AW-1:0] dest_index;
   logic              dest_is_sp;
   logic [XLEN-1:0]   write_value;
   logic              flags_written;
   logic [NZCV_W-1:0] nzcv;
   logic              undefined;

   modport source (output valid, write_enable, dest_index, dest_is_sp, write_value,
                   flags_written, nzcv, undefined, input ready);
   modport sink   (input valid, write_enable, dest_index, dest_is_sp, write_value,
                   flags_written, nzcv, undefined, output ready);
endinterface
`default_nettype wire

// File: rtl/aidp_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module aidp_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/aidp_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer divider
// Restoring divider, one quotient bit per cycle, for UDIV and SDIV.
// -----------------------------------------------------------------------------
module aidp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      sf,
   input  logic                      is_signed,
   input  logic [aidp_pkg::XLEN-1:0] dividend,
   input  logic [aidp_pkg::XLEN-1:0] divisor,
   output logic                      done,
   output logic [aidp_pkg::XLEN-1:0] quotient
);
   import aidp_pkg::*;

   logic [XLEN-1:0] m;
   logic            a_neg, b_neg;
   logic [XLEN-1:0] ua, ub;
   logic [XLEN:0]   shifted;
   logic [XLEN+1:0] diff;
   logic            ge;
   logic [XLEN-1:0] q_signed;

   logic            busy_ff, done_ff;
   logic [6:0]      cnt_ff;
   logic [XLEN-1:0] rem_ff, quo_ff, dvs_ff;
   logic            neg_ff, zero_ff, sf_ff;

   always_comb begin
      m       = sf ? {XLEN{1'b1}} : {32'b0, 32'hFFFF_FFFF};
      a_neg   = is_signed && (sf ? dividend[63] : dividend[31]);
      b_neg   = is_signed && (sf ? divisor[63] : divisor[31]);
      ua      = a_neg ? ((~dividend + 64'd1) & m) : (dividend & m);
      ub      = b_neg ? ((~divisor + 64'd1) & m) : (divisor & m);
      shifted = {rem_ff, quo_ff[XLEN-1]};
      diff    = {1'b0, shifted} - {2'b0, dvs_ff};
      ge      = !diff[XLEN+1];
      q_signed = neg_ff ? (~quo_ff + 64'd1) : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= sf ? 7'd64 : 7'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // A 32-bit dividend sits in the upper half so the same shift works.
         quo_ff  <= sf ? ua : {ua[31:0], 32'b0};
         rem_ff  <= '0;
         dvs_ff  <= ub;
         neg_ff  <= a_neg ^ b_neg;
         zero_ff <= (ub == '0);
         sf_ff   <= sf;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[XLEN-1:0] : shifted[XLEN-1:0];
         quo_ff <= {quo_ff[XLEN-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0
                   : (q_signed & (sf_ff ? {XLEN{1'b1}} : {32'b0, 32'hFFFF_FFFF}));
endmodule
`default_nettype wire

// File: rtl/aidp_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer data-processing datapath
// Register file, stack pointer, flags, two execute stages, divider and the
// result register.
// -----------------------------------------------------------------------------
module aidp_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [aidp_pkg::OP_W-1:0]        req_op,
   input  logic [aidp_pkg::INSTR_W-1:0]     req_instr_word,
   input  aidp_pkg::aidp_cmd_type           cmd,
   output aidp_pkg::aidp_sts_type           sts,
   output logic                             rsp_write_enable,
   output logic [aidp_pkg::REG_AW-1:0]      rsp_dest_index,
   output logic                             rsp_dest_is_sp,
   output logic [aidp_pkg::XLEN-1:0]        rsp_write_value,
   output logic                             rsp_flags_written,
   output logic [aidp_pkg::NZCV_W-1:0]      rsp_nzcv,
   output logic                             rsp_undefined
);
   import aidp_pkg::*;

   typedef struct packed {
      logic            ok;
      logic [XLEN-1:0] wm;
      logic [XLEN-1:0] tm;
   } bm_type;

   function automatic logic [XLEN-1:0] ones(input logic [6:0] k);
      return (k >= 7'd64) ? {XLEN{1'b1}} : ((64'd1 << k) - 64'd1);
   endfunction

   function automatic logic [XLEN-1:0] shift_val(input logic [XLEN-1:0] x,
                                                 input logic [1:0] kind,
                                                 input logic [5:0] amt,
                                                 input logic sf);
      logic [XLEN-1:0] r;
      logic [31:0]     x32, r32;
      logic [4:0]      a32;
      x32 = x[31:0];
      a32 = amt[4:0];
      r   = '0;
      r32 = '0;
      if (sf) begin
         unique case (kind)
            2'd0: r = x << amt;
            2'd1: r = x >> amt;
            2'd2: r = $unsigned($signed(x) >>> amt);
            2'd3: r = (x >> amt) | (x << (7'd64 - {1'b0, amt}));
         endcase
      end else begin
         unique case (kind)
            2'd0: r32 = x32 << a32;
            2'd1: r32 = x32 >> a32;
            2'd2: r32 = $unsigned($signed(x32) >>> a32);
            2'd3: r32 = (x32 >> a32) | (x32 << (6'd32 - {1'b0, a32}));
         endcase
         r = {32'b0, r32};
      end
      return r;
   endfunction

   function automatic bm_type bit_masks(input logic nbit, input logic [5:0] imms,
                                        input logic [5:0] immr, input logic immediate,
                                        input logic sf);
      bm_type          res;
      logic [6:0]      v, esize;
      logic [2:0]      len;
      logic [5:0]      levels, s, r, d;
      logic [XLEN-1:0] emask, we, te, w, t;
      v   = {nbit, ~imms};
      len = 3'd0;
      for (int j = 1; j < 7; j++) begin
         if (v[j]) len = 3'(j);
      end
      esize  = 7'd1 << len;
      levels = 6'(esize - 7'd1);
      s      = imms & levels;
      r      = immr & levels;
      d      = (s - r) & levels;
      emask  = ones(esize);
      we     = ones({1'b0, s} + 7'd1);
      we     = ((we >> r) | (we << (esize - {1'b0, r}))) & emask;
      te     = ones({1'b0, d} + 7'd1);
      w      = we;
      t      = te;
      // Replicate the element across the word, doubling each step.
      for (int j = 1; j < 6; j++) begin
         if (j >= int'(len)) begin
            w = w | (w << (1 << j));
            t = t | (t << (1 << j));
         end
      end
      res.ok = (len != 3'd0) && !(len == 3'd6 && !sf) && !(immediate && s == levels);
      res.wm = w;
      res.tm = t;
      return res;
   endfunction

   function automatic logic cond_holds(input logic [3:0] c, input logic [NZCV_W-1:0] f);
      logic h;
      unique case (c[3:1])
         3'd0: h = f[2];
         3'd1: h = f[1];
         3'd2: h = f[3];
         3'd3: h = f[0];
         3'd4: h = f[1] && !f[2];
         3'd5: h = (f[3] == f[0]);
         3'd6: h = (f[3] == f[0]) && !f[2];
         3'd7: h = 1'b1;
      endcase
      if (c[0] && c != 4'hF) h = !h;
      return h;
   endfunction

   function automatic logic [6:0] clz64(input logic [XLEN-1:0] x);
      logic [6:0] cnt;
      cnt = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) cnt = 7'(63 - i);
      end
      return cnt;
   endfunction

   // Held instruction.
   logic [OP_W-1:0]    op_ff;
   logic [INSTR_W-1:0] instr_ff;

   // Architectural state.
   logic [GPR_DEPTH-1:0] gpr_valid_ff;
   logic [XLEN-1:0]      sp_ff;
   logic [NZCV_W-1:0]    flags_ff;

   // Operands and stage registers.
   logic [XLEN-1:0]   a_ff, b_ff, d_ff;
   logic [XLEN-1:0]   e1_b_ff, e1_sh_ff, e1_wm_ff, e1_tm_ff;
   logic              e1_cin_ff, e1_ok_ff, e1_div_ff;
   logic [XLEN-1:0]   res_ff;
   logic [NZCV_W-1:0] nf_ff;
   logic              setf_ff, ok_ff;

   // Result register.
   logic              out_we_ff, out_sp_ff, out_fw_ff, out_undef_ff;
   logic [REG_AW-1:0] out_idx_ff;
   logic [XLEN-1:0]   out_val_ff;
   logic [NZCV_W-1:0] out_nzcv_ff;

   // Decoded fields.
   logic              sf, b30, b29, nb;
   logic [1:0]        opc;
   logic [REG_AW-1:0] rd, rn, rm;
   logic [5:0]        immr, imms;
   logic [XLEN-1:0]   m;

   logic [REG_AW-1:0] ram_a_addr;
   logic [XLEN-1:0]   ram_a_data, ram_b_data;
   logic              gpr_wr;
   logic [XLEN-1:0]   a_in, b_in, d_in;

   // Stage one.
   logic [XLEN-1:0] imm12, sh_x, sh_out, e1_b_in;
   logic [1:0]      sh_kind;
   logic [5:0]      sh_amt;
   logic            e1_cin_in, e1_ok_in, e1_div_in;
   bm_type          bm;

   // Stage two.
   logic [XLEN-1:0]   add_x, add_r, ovf, log_src, log_r, imm_sh, top, bot, ex_r;
   logic [XLEN-1:0]   rb64, r16, r32, r64, cls_t, os_r;
   logic [XLEN:0]     sum;
   logic              add_c, add_v, add_n, log_n;
   logic [5:0]        mw_pos;
   logic [6:0]        clz_r, cls_r;
   logic [XLEN-1:0]   res_in;
   logic [NZCV_W-1:0] nf_in;
   logic              setf_in;

   // Commit.
   logic              spok, wr_sp;
   logic [NZCV_W-1:0] flags_new;
   logic [XLEN-1:0]   div_q;
   logic              div_done;

   always_comb begin
      sf   = instr_ff[31];
      b30  = instr_ff[30];
      b29  = instr_ff[29];
      opc  = instr_ff[30:29];
      nb   = instr_ff[22];
      rd   = instr_ff[4:0];
      rn   = instr_ff[9:5];
      rm   = instr_ff[20:16];
      immr = instr_ff[21:16];
      imms = instr_ff[15:10];
      m    = sf ? {XLEN{1'b1}} : {32'b0, 32'hFFFF_FFFF};
   end

   // The first port reads Rn, then Rd; the second port reads Rm.
   assign ram_a_addr = cmd.load_ops ? rd : req_instr_word[9:5];

   aidp_ram #(.WIDTH(XLEN), .DEPTH(GPR_DEPTH)) u_gpr_a (
      .clock   (clock),
      .wr_en   (gpr_wr),
      .wr_addr (rd),
      .wr_data (res_ff),
      .rd_addr (ram_a_addr),
      .rd_data (ram_a_data)
   );

   aidp_ram #(.WIDTH(XLEN), .DEPTH(GPR_DEPTH)) u_gpr_b (
      .clock   (clock),
      .wr_en   (gpr_wr),
      .wr_addr (rd),
      .wr_data (res_ff),
      .rd_addr (req_instr_word[20:16]),
      .rd_data (ram_b_data)
   );

   always_comb begin
      if (op_ff == OP_ADDSUB_IMM && rn == ZR_INDEX) begin
         a_in = sp_ff & m;
      end else if (rn == ZR_INDEX || !gpr_valid_ff[rn]) begin
         a_in = '0;
      end else begin
         a_in = ram_a_data & m;
      end
      b_in = (rm == ZR_INDEX || !gpr_valid_ff[rm]) ? '0 : (ram_b_data & m);
      d_in = (rd == ZR_INDEX || !gpr_valid_ff[rd]) ? '0 : (ram_a_data & m);
   end

   // Stage one: operand shaping, shifter and bit masks.
   always_comb begin
      imm12 = {52'b0, instr_ff[21:10]} << (nb ? 12 : 0);
      priority if (op_ff == OP_BITFIELD) begin
         sh_x    = a_ff;
         sh_kind = 2'd3;
         sh_amt  = immr;
      end else if (op_ff == OP_TWO_SRC) begin
         sh_x    = a_ff;
         sh_kind = imms[1:0];
         sh_amt  = b_ff[5:0];
      end else begin
         sh_x    = b_ff;
         sh_kind = instr_ff[23:22];
         sh_amt  = imms;
      end
      sh_out = shift_val(sh_x, sh_kind, sh_amt, sf);
      bm     = bit_masks(nb, imms, immr, op_ff == OP_LOGIC_IMM, sf);

      e1_b_in   = b_ff;
      e1_cin_in = 1'b0;
      e1_ok_in  = 1'b0;
      unique case (op_ff)
         OP_ADDSUB_IMM: begin
            e1_b_in   = b30 ? (~imm12 & m) : imm12;
            e1_cin_in = b30;
            e1_ok_in  = 1'b1;
         end
         OP_LOGIC_IMM: e1_ok_in = !(!sf && nb) && bm.ok;
         OP_MOVE_WIDE: e1_ok_in = (opc != 2'd1) && !(!sf && instr_ff[22]);
         OP_BITFIELD: begin
            e1_ok_in = (opc != 2'd3) && !(sf && !nb)
                       && !(!sf && (nb || immr[5] || imms[5])) && bm.ok;
         end
         OP_EXTRACT: begin
            e1_ok_in = (opc == 2'd0) && !instr_ff[21] && (nb == sf) && !(!sf && imms[5]);
         end
         OP_ONE_SRC: begin
            e1_ok_in = !b29 && (instr_ff[20:16] == 5'd0) && (imms <= OS_CLS)
                       && !(imms == OS_REV64 && !sf);
         end
         OP_TWO_SRC: begin
            e1_ok_in = !b29 && (imms == TS_UDIV || imms == TS_SDIV || imms == TS_LSLV
                                || imms == TS_LSRV || imms == TS_ASRV || imms == TS_RORV);
         end
         OP_LOGIC_REG: begin
            e1_b_in  = instr_ff[21] ? (~sh_out & m) : sh_out;
            e1_ok_in = !(!sf && imms[5]);
         end
         OP_ADDSUB_REG: begin
            e1_b_in   = b30 ? (~sh_out & m) : sh_out;
            e1_cin_in = b30;
            e1_ok_in  = (instr_ff[23:22] != 2'd3) && !(!sf && imms[5]);
         end
         OP_CARRY: begin
            e1_b_in   = b30 ? (~b_ff & m) : b_ff;
            e1_cin_in = flags_ff[1];
            e1_ok_in  = 1'b1;
         end
         OP_CONDSEL: begin
            // A failed condition gives Rm, Rm + 1, ~Rm or -Rm through the adder.
            e1_b_in   = b30 ? (~b_ff & m) : b_ff;
            e1_cin_in = instr_ff[10];
            e1_ok_in  = !b29 && !instr_ff[11];
         end
         default: e1_ok_in = 1'b0;
      endcase
      e1_div_in = e1_ok_in && (op_ff == OP_TWO_SRC) && (imms == TS_UDIV || imms == TS_SDIV);
   end

   // Stage two: adder, logic, moves, bitfield, extract and one-source.
   always_comb begin
      add_x = (op_ff == OP_CONDSEL) ? '0 : a_ff;
      sum   = {1'b0, add_x} + {1'b0, e1_b_ff} + {{XLEN{1'b0}}, e1_cin_ff};
      add_r = sum[XLEN-1:0] & m;
      ovf   = (add_x ^ add_r) & (e1_b_ff ^ add_r);
      add_c = sf ? sum[64] : sum[32];
      add_v = sf ? ovf[63] : ovf[31];
      add_n = sf ? add_r[63] : add_r[31];

      log_src = (op_ff == OP_LOGIC_IMM) ? e1_wm_ff : e1_b_ff;
      unique case (opc)
         2'd1:    log_r = (a_ff | log_src) & m;
         2'd2:    log_r = (a_ff ^ log_src) & m;
         default: log_r = (a_ff & log_src) & m;
      endcase
      log_n = sf ? log_r[63] : log_r[31];

      mw_pos = {instr_ff[22:21], 4'b0};
      imm_sh = {48'b0, instr_ff[20:5]} << mw_pos;

      top = a_ff[imms] ? m : '0;
      bot = (d_ff & ~e1_wm_ff) | (e1_sh_ff & e1_wm_ff);

      ex_r = (imms == 6'd0) ? b_ff
           : (((b_ff >> imms) | (a_ff << ((sf ? 7'd64 : 7'd32) - {1'b0, imms}))) & m);

      for (int i = 0; i < 64; i++) begin
         rb64[i] = a_ff[63-i];
      end
      for (int i = 0; i < 8; i++) begin
         r16[8*(i^1) +: 8] = a_ff[8*i +: 8];
         r32[8*(i^3) +: 8] = a_ff[8*i +: 8];
         r64[8*(i^7) +: 8] = a_ff[8*i +: 8];
      end
      // Leading sign bits are leading zeros of neighbouring-bit differences.
      cls_t = (a_ff ^ (a_ff >> 1)) & (m >> 1);
      clz_r = clz64(a_ff) - (sf ? 7'd0 : 7'd32);
      cls_r = clz64(cls_t) - (sf ? 7'd1 : 7'd33);
      unique case (imms)
         OS_RBIT:  os_r = sf ? rb64 : {32'b0, rb64[63:32]};
         OS_REV16: os_r = r16;
         OS_REV32: os_r = r32;
         OS_REV64: os_r = r64;
         OS_CLZ:   os_r = {57'b0, clz_r};
         default:  os_r = {57'b0, cls_r};
      endcase

      res_in  = '0;
      nf_in   = '0;
      setf_in = 1'b0;
      unique case (op_ff)
         OP_ADDSUB_IMM, OP_ADDSUB_REG, OP_CARRY: begin
            res_in  = add_r;
            nf_in   = {add_n, add_r == '0, add_c, add_v};
            setf_in = b29;
         end
         OP_LOGIC_IMM, OP_LOGIC_REG: begin
            res_in  = log_r;
            nf_in   = {log_n, log_r == '0, 2'b00};
            setf_in = (opc == LOGIC_ANDS);
         end
         OP_MOVE_WIDE: begin
            unique case (opc)
               2'd0:    res_in = ~imm_sh & m;
               2'd2:    res_in = imm_sh & m;
               default: res_in = ((d_ff & ~({48'b0, 16'hFFFF} << mw_pos)) | imm_sh) & m;
            endcase
         end
         OP_BITFIELD: begin
            unique case (opc)
               2'd0:    res_in = ((top & ~e1_tm_ff) | (e1_sh_ff & e1_wm_ff & e1_tm_ff)) & m;
               2'd1:    res_in = ((d_ff & ~e1_tm_ff) | (bot & e1_tm_ff)) & m;
               default: res_in = e1_sh_ff & e1_wm_ff & e1_tm_ff & m;
            endcase
         end
         OP_EXTRACT:  res_in = ex_r;
         OP_ONE_SRC:  res_in = os_r & m;
         OP_TWO_SRC:  res_in = e1_sh_ff & m;
         OP_CONDSEL:  res_in = cond_holds(instr_ff[15:12], flags_ff) ? a_ff : add_r;
         default:     res_in = '0;
      endcase
   end

   aidp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .sf        (sf),
      .is_signed (instr_ff[10]),
      .dividend  (a_ff),
      .divisor   (b_ff),
      .done      (div_done),
      .quotient  (div_q)
   );

   assign sts.is_div   = e1_div_ff;
   assign sts.div_done = div_done;

   always_comb begin
      spok      = (op_ff == OP_ADDSUB_IMM) && !b29;
      gpr_wr    = cmd.commit && ok_ff && (rd != ZR_INDEX);
      wr_sp     = ok_ff && (rd == ZR_INDEX) && spok;
      flags_new = (ok_ff && setf_ff) ? nf_ff : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_valid_ff <= '0;
         sp_ff        <= '0;
         flags_ff     <= '0;
      end else if (cmd.commit) begin
         if (gpr_wr) gpr_valid_ff[rd] <= 1'b1;
         if (wr_sp) sp_ff <= res_ff;
         flags_ff <= flags_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_op;
         instr_ff <= req_instr_word;
      end
      if (cmd.load_ops) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (cmd.load_stage1) begin
         d_ff      <= d_in;
         e1_b_ff   <= e1_b_in;
         e1_sh_ff  <= sh_out;
         e1_wm_ff  <= bm.wm;
         e1_tm_ff  <= bm.tm;
         e1_cin_ff <= e1_cin_in;
         e1_ok_ff  <= e1_ok_in;
         e1_div_ff <= e1_div_in;
      end
      if (cmd.load_stage2) begin
         res_ff  <= res_in;
         nf_ff   <= nf_in;
         setf_ff <= setf_in;
         ok_ff   <= e1_ok_ff;
      end else if (cmd.div_take) begin
         res_ff <= div_q;
      end
      if (cmd.commit) begin
         out_we_ff    <= gpr_wr || wr_sp;
         out_idx_ff   <= (gpr_wr || wr_sp) ? rd : '0;
         out_sp_ff    <= wr_sp;
         out_val_ff   <= (gpr_wr || wr_sp) ? res_ff : '0;
         out_fw_ff    <= ok_ff && setf_ff;
         out_nzcv_ff  <= flags_new;
         out_undef_ff <= !ok_ff;
      end
   end

   assign rsp_write_enable  = out_we_ff;
   assign rsp_dest_index    = out_idx_ff;
   assign rsp_dest_is_sp    = out_sp_ff;
   assign rsp_write_value   = out_val_ff;
   assign rsp_flags_written = out_fw_ff;
   assign rsp_nzcv          = out_nzcv_ff;
   assign rsp_undefined     = out_undef_ff;
endmodule
`default_nettype wire

// File: rtl/aidp_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer data-processing controller
// Sequences register reads, the two execute stages, division and write-back.
// -----------------------------------------------------------------------------
module aidp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  aidp_pkg::aidp_sts_type sts,
   output aidp_pkg::aidp_cmd_type cmd
);
   import aidp_pkg::*;

   aidp_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.load_ops = 1'b1;
            state_in     = ST_OPER;
         end
         ST_OPER: begin
            cmd.load_stage1 = 1'b1;
            state_in        = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.load_stage2 = 1'b1;
            if (sts.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // Write back only once the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// File: rtl/aarch64_integer_dp_execute.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer data-processing execute unit
// Executes one integer data-processing instruction per request beat against
// the register file, stack pointer and NZCV flags, and returns one result beat.
// -----------------------------------------------------------------------------
//  Channel   Direction  Beat carries
//  req_chan  in         op, instr_word
//  rsp_chan  out        write_enable, dest_index, dest_is_sp, write_value,
//                       flags_written, nzcv, undefined
//
//  From acceptance to write-back an instruction goes through two register file
//  reads through the registered RAM ports, two execute stages and commit. UDIV
//  and SDIV also run through the divider, one quotient bit per cycle. Reset is
//  synchronous and clears the registers, stack pointer and flags at once. A
//  stalled result waits in the output register; the next instruction is taken
//  as soon as it has committed.
// -----------------------------------------------------------------------------
module aarch64_integer_dp_execute (
   input  logic       clock,
   input  logic       reset,
   aidp_req_if.sink   req_chan,
   aidp_rsp_if.source rsp_chan
);
   import aidp_pkg::*;

   aidp_cmd_type cmd;
   aidp_sts_type sts;

   aidp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   aidp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_chan.op),
      .req_instr_word    (req_chan.instr_word),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_write_enable  (rsp_chan.write_enable),
      .rsp_dest_index    (rsp_chan.dest_index),
      .rsp_dest_is_sp    (rsp_chan.dest_is_sp),
      .rsp_write_value   (rsp_chan.write_value),
      .rsp_flags_written (rsp_chan.flags_written),
      .rsp_nzcv          (rsp_chan.nzcv),
      .rsp_undefined     (rsp_chan.undefined)
   );

   // Only one instruction is in flight at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second instruction accepted while one is in flight");

   // A commit always presents its result beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_chan.valid)
      else $error("commit without a result beat");

   // The quotient is taken only when the divider has finished.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_take |-> sts.div_done)
      else $error("quotient taken before the divider finished");
endmodule
`default_nettype wire

// File: dv/tb_aarch64_integer_dp_execute.sv
`default_nettype none
// -----------------------------------------------------------------------------
// AArch64 integer data-processing execute unit testbench
// Drives instruction beats into the unit and checks each result beat against
// the one in its table row, if any, else an internal model of the register
// file, stack pointer and NZCV flags. A short table of hand-picked instructions
// is followed by random, mostly well-formed encodings. The sender works in
// bursts; the receiver stalls on a pattern of its own, once for a long stretch.
// -----------------------------------------------------------------------------
module tb_aarch64_integer_dp_execute;
   timeunit 1ns;
   timeprecision 1ps;

   import aidp_pkg::*;

   localparam int unsigned RANDOM_INSTRS = 1450;
   localparam int unsigned HOLD_CYCLES   = 400;

   // Group codes past the last allocated group.
   localparam logic [OP_W-1:0] OP_UNALLOC_FIRST = 4'd11;
   localparam logic [OP_W-1:0] OP_UNALLOC_LAST  = 4'd15;

   // Shift types of the shifted-register forms.
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;

   // Move-wide opcodes.
   localparam logic [1:0] MW_MOVN     = 2'd0;
   localparam logic [1:0] MW_RESERVED = 2'd1;
   localparam logic [1:0] MW_MOVZ     = 2'd2;
   localparam logic [1:0] MW_MOVK     = 2'd3;

   // Logical opcodes other than ANDS.
   localparam logic [1:0] LOGIC_AND = 2'd0;
   localparam logic [1:0] LOGIC_ORR = 2'd1;
   localparam logic [1:0] LOGIC_EOR = 2'd2;

   // Bitfield opcodes.
   localparam logic [1:0] BF_SBFM     = 2'd0;
   localparam logic [1:0] BF_BFM      = 2'd1;
   localparam logic [1:0] BF_RESERVED = 2'd3;

   // Condition field groups, taken from bits 3:1 of the condition.
   localparam logic [2:0] CG_EQ = 3'd0;
   localparam logic [2:0] CG_CS = 3'd1;
   localparam logic [2:0] CG_MI = 3'd2;
   localparam logic [2:0] CG_VS = 3'd3;
   localparam logic [2:0] CG_HI = 3'd4;
   localparam logic [2:0] CG_GE = 3'd5;
   localparam logic [2:0] CG_GT = 3'd6;
   localparam logic [3:0] COND_NV = 4'b1111;

   typedef struct packed {
      logic              write_enable;
      logic [REG_AW-1:0] dest_index;
      logic              dest_is_sp;
      logic [XLEN-1:0]   write_value;
      logic              flags_written;
      logic [NZCV_W-1:0] nzcv;
      logic              undefined;
   } dp_result_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [INSTR_W-1:0] word;
      bit                 typed;
      dp_result_type      res;
   } instr_row_type;

   localparam dp_result_type NO_RES = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aidp_req_if req_chan ();
   aidp_rsp_if rsp_chan ();

   aarch64_integer_dp_execute dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // Architectural state as the unit should hold it.
   logic [XLEN-1:0]   arch_gpr [31];
   logic [XLEN-1:0]   arch_sp;
   logic [NZCV_W-1:0] arch_flags;

   dp_result_type pending_results [$];
   int            error_count = 0;
   int            beats_sent  = 0;
   logic          hold_off    = 1'b0;

   // Hand-picked instructions. The first rows run from reset with the flags
   // still clear, so their results can be written down directly.
   instr_row_type directed_rows [] = '{
      '{OP_UNALLOC_FIRST, 32'h00000000, 1'b1, '{1'b0, 5'd0, 1'b0, 64'h0, 1'b0, 4'd0, 1'b1}},
      '{OP_MOVE_WIDE, 32'hD2FFFFE0, 1'b1,
        '{1'b1, 5'd0, 1'b0, 64'hFFFF000000000000, 1'b0, 4'd0, 1'b0}},
      '{OP_MOVE_WIDE, 32'h92800001, 1'b1,
        '{1'b1, 5'd1, 1'b0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 4'd0, 1'b0}},
      '{OP_MOVE_WIDE, 32'h52B00002, 1'b1,
        '{1'b1, 5'd2, 1'b0, 64'h0000000080000000, 1'b0, 4'd0, 1'b0}},
      '{OP_MOVE_WIDE, 32'hD2F00005, 1'b1,
        '{1'b1, 5'd5, 1'b0, 64'h8000000000000000, 1'b0, 4'd0, 1'b0}},
      '{OP_TWO_SRC, 32'h9AC10CA6, 1'b1,
        '{1'b1, 5'd6, 1'b0, 64'h8000000000000000, 1'b0, 4'd0, 1'b0}},
      '{OP_TWO_SRC, 32'h9ADF08A7, 1'b1,
        '{1'b1, 5'd7, 1'b0, 64'h0, 1'b0, 4'd0, 1'b0}},
      '{OP_TWO_SRC, 32'h1AC10C48, 1'b1,
        '{1'b1, 5'd8, 1'b0, 64'h0000000080000000, 1'b0, 4'd0, 1'b0}},
      '{OP_ADDSUB_REG, 32'hAB000003, 1'b0, NO_RES},
      '{OP_ADDSUB_IMM, 32'hD10007FF, 1'b0, NO_RES},
      '{OP_ADDSUB_IMM, 32'hB100001F, 1'b0, NO_RES},
      '{OP_TWO_SRC, 32'h9AC12009, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'hDAC0000A, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'h5AC00C00, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'hDAC010AB, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'h5AC0144C, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'hDAC0040D, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'hDAC008AE, 1'b0, NO_RES},
      '{OP_ONE_SRC, 32'hDAC00CAF, 1'b0, NO_RES},
      '{OP_LOGIC_IMM, 32'hF2400030, 1'b0, NO_RES},
      '{OP_LOGIC_IMM, 32'h1200FC00, 1'b0, NO_RES},
      '{OP_BITFIELD, 32'h937FFCB1, 1'b0, NO_RES},
      '{OP_BITFIELD, 32'h33041C32, 1'b0, NO_RES},
      '{OP_BITFIELD, 32'hD3483C13, 1'b0, NO_RES},
      '{OP_EXTRACT, 32'h93C50014, 1'b0, NO_RES},
      '{OP_EXTRACT, 32'h93C5FC15, 1'b0, NO_RES},
      '{OP_CARRY, 32'h9A010036, 1'b0, NO_RES},
      '{OP_CARRY, 32'h7A010037, 1'b0, NO_RES},
      '{OP_CONDSEL, 32'h9A81F418, 1'b0, NO_RES},
      '{OP_CONDSEL, 32'hDA8104B9, 1'b0, NO_RES},
      '{OP_LOGIC_REG, 32'hCAE5FC1A, 1'b0, NO_RES},
      '{OP_LOGIC_REG, 32'h6A017C5B, 1'b0, NO_RES},
      '{OP_ADDSUB_REG, 32'h8BC00000, 1'b0, NO_RES},
      '{OP_ADDSUB_REG, 32'hEB81FCBC, 1'b0, NO_RES},
      '{OP_MOVE_WIDE, 32'hF2824680, 1'b0, NO_RES},
      '{OP_TWO_SRC, 32'h1AC12859, 1'b0, NO_RES},
      '{OP_TWO_SRC, 32'h9AC12CBE, 1'b0, NO_RES},
      '{OP_UNALLOC_LAST, 32'hFFFFFFFF, 1'b0, NO_RES}
   };

   function automatic logic [XLEN-1:0] size_mask(input int ds);
      return ds == 64 ? '1 : 64'h00000000FFFFFFFF;
   endfunction

   function automatic logic [XLEN-1:0] low_ones(input int k);
      return k >= 64 ? '1 : ((64'd1 << k) - 64'd1);
   endfunction

   function automatic logic [XLEN-1:0] rotate_right(input logic [XLEN-1:0] x,
                                                    input int sh, input int ds);
      logic [XLEN-1:0] m;
      m  = size_mask(ds) & low_ones(ds);
      x  = x & m;
      sh = sh % ds;
      if (sh == 0) return x;
      return ((x >> sh) | (x << (ds - sh))) & m;
   endfunction

   function automatic logic [XLEN-1:0] shift_by(input logic [XLEN-1:0] x, input logic [1:0] kind,
                                                input int amt, input int ds);
      logic [XLEN-1:0] m;
      logic [XLEN-1:0] r;
      m   = size_mask(ds);
      x   = x & m;
      amt = amt % ds;
      case (kind)
         SHIFT_LSL: r = (x << amt) & m;
         SHIFT_LSR: r = x >> amt;
         SHIFT_ASR: begin
            r = x >> amt;
            if (x[ds-1]) r = r | (m & ~(m >> amt));
         end
         default: r = rotate_right(x, amt, ds);
      endcase
      return r;
   endfunction

   // Sum with carry in; nzcv receives the flags of the sum at the data size.
   function automatic logic [XLEN-1:0] sum_with_flags(input logic [XLEN-1:0] x,
                                                      input logic [XLEN-1:0] y, input logic cin,
                                                      input int ds,
                                                      output logic [NZCV_W-1:0] nzcv);
      logic [XLEN:0]   full;
      logic [XLEN-1:0] r;
      logic [XLEN-1:0] m;
      logic            c;
      m    = size_mask(ds);
      x    = x & m;
      y    = y & m;
      full = {1'b0, x} + {1'b0, y} + {64'd0, cin};
      r    = full[XLEN-1:0] & m;
      c    = ds == 64 ? full[64] : full[32];
      nzcv = {r[ds-1], r == 64'd0, c, ((x ^ r) & (y ^ r)) >> (ds - 1) != 64'd0};
      return r;
   endfunction

   function automatic bit decode_masks(input logic nbit, input logic [5:0] imms,
                                       input logic [5:0] immr, input bit immediate,
                                       input int ds, output logic [XLEN-1:0] wm,
                                       output logic [XLEN-1:0] tm);
      logic [6:0]      v;
      int              len;
      int              esize;
      int              levels;
      int              s;
      int              r;
      int              d;
      logic [XLEN-1:0] we;
      logic [XLEN-1:0] te;
      wm  = '0;
      tm  = '0;
      v   = {nbit, ~imms};
      len = -1;
      for (int k = 0; k < 7; k++) if (v[k]) len = k;
      if (len < 1) return 1'b0;
      esize = 1 << len;
      if (esize > ds) return 1'b0;
      levels = esize - 1;
      if (immediate && (int'(imms) & levels) == levels) return 1'b0;
      s  = int'(imms) & levels;
      r  = int'(immr) & levels;
      d  = (s - r) & levels;
      we = rotate_right(low_ones(s + 1), r, esize);
      te = low_ones(d + 1);
      for (int pos = 0; pos < ds; pos += esize) begin
         wm = wm | (we << pos);
         tm = tm | (te << pos);
      end
      return 1'b1;
   endfunction

   function automatic bit condition_true(input logic [3:0] cond, input logic [NZCV_W-1:0] f);
      bit h;
      case (cond[3:1])
         CG_EQ:   h = f[2];
         CG_CS:   h = f[1];
         CG_MI:   h = f[3];
         CG_VS:   h = f[0];
         CG_HI:   h = f[1] && !f[2];
         CG_GE:   h = f[3] == f[0];
         CG_GT:   h = (f[3] == f[0]) && !f[2];
         default: h = 1'b1;
      endcase
      if (cond[0] && cond != COND_NV) h = !h;
      return h;
   endfunction

   function automatic logic [XLEN-1:0] read_gpr(input logic [4:0] r, input int ds);
      return r == ZR_INDEX ? 64'd0 : (arch_gpr[r] & size_mask(ds));
   endfunction

   // Executes one instruction on the architectural state and returns its beat.
   function automatic dp_result_type execute_instr(input logic [OP_W-1:0] op,
                                                   input logic [INSTR_W-1:0] w);
      dp_result_type     o;
      logic              sf;
      int                ds;
      logic [XLEN-1:0]   m;
      logic [4:0]        rd;
      logic [4:0]        rn;
      logic [4:0]        rm;
      logic [5:0]        immr;
      logic [5:0]        imms;
      logic [1:0]        opc;
      logic              nb;
      bit                ok;
      bit                spok;
      bit                setf;
      logic [NZCV_W-1:0] nf;
      logic [XLEN-1:0]   res;
      logic [XLEN-1:0]   a;
      logic [XLEN-1:0]   b;
      logic [XLEN-1:0]   wm;
      logic [XLEN-1:0]   tm;
      logic [XLEN-1:0]   imm;
      logic [XLEN-1:0]   q;
      int                pos;
      int                cb;
      int                cnt;
      o    = '0;
      sf   = w[31];
      ds   = sf ? 64 : 32;
      m    = size_mask(ds);
      rd   = w[4:0];
      rn   = w[9:5];
      rm   = w[20:16];
      immr = w[21:16];
      imms = w[15:10];
      opc  = w[30:29];
      nb   = w[22];
      ok   = 1'b1;
      spok = 1'b0;
      setf = 1'b0;
      nf   = '0;
      res  = '0;
      cnt  = 0;
      case (op)
         OP_ADDSUB_IMM: begin
            imm = nb ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
            a   = (rn == ZR_INDEX ? arch_sp : arch_gpr[rn]) & m;
            if (w[30]) res = sum_with_flags(a, ~imm & m, 1'b1, ds, nf);
            else res = sum_with_flags(a, imm, 1'b0, ds, nf);
            setf = w[29];
            spok = !w[29];
         end
         OP_LOGIC_IMM: begin
            if (!sf && nb) ok = 1'b0;
            else if (!decode_masks(nb, imms, immr, 1'b1, ds, wm, tm)) ok = 1'b0;
            else begin
               a = read_gpr(rn, ds);
               case (opc)
                  LOGIC_ORR: res = a | wm;
                  LOGIC_EOR: res = a ^ wm;
                  default:   res = a & wm;
               endcase
               res = res & m;
               if (opc == LOGIC_ANDS) begin
                  setf = 1'b1;
                  nf   = {res[ds-1], res == 64'd0, 2'b00};
               end
            end
         end
         OP_MOVE_WIDE: begin
            imm = {48'd0, w[20:5]};
            if (opc == MW_RESERVED || (!sf && w[22])) ok = 1'b0;
            else begin
               pos = int'(w[22:21]) * 16;
               case (opc)
                  MW_MOVN: res = ~(imm << pos) & m;
                  MW_MOVZ: res = (imm << pos) & m;
                  default: res = ((read_gpr(rd, ds) & ~(64'hFFFF << pos)) | (imm << pos)) & m;
               endcase
            end
         end
         OP_BITFIELD: begin
            if (opc == BF_RESERVED || (sf && !nb) || (!sf && (nb || immr[5] || imms[5])))
               ok = 1'b0;
            else if (!decode_masks(nb, imms, immr, 1'b0, ds, wm, tm)) ok = 1'b0;
            else begin
               a = read_gpr(rn, ds);
               b = rotate_right(a, int'(immr), ds);
               if (opc == BF_SBFM) begin
                  q   = a[imms] ? m : 64'd0;
                  res = (q & ~tm) | (b & wm & tm);
               end else if (opc == BF_BFM) begin
                  q   = read_gpr(rd, ds);
                  imm = (q & ~wm) | (b & wm);
                  res = (q & ~tm) | (imm & tm);
               end else begin
                  res = b & wm & tm;
               end
               res = res & m;
            end
         end
         OP_EXTRACT: begin
            if (opc != 2'd0 || w[21] || nb != sf || (!sf && imms[5])) ok = 1'b0;
            else begin
               a   = read_gpr(rn, ds);
               b   = read_gpr(rm, ds);
               res = imms == 6'd0 ? b : (((b >> imms) | (a << (ds - int'(imms)))) & m);
            end
         end
         OP_ONE_SRC: begin
            a = read_gpr(rn, ds);
            if (w[29] || rm != 5'd0) ok = 1'b0;
            else if (imms == OS_RBIT) begin
               for (int i = 0; i < ds; i++) if (a[i]) res[ds-1-i] = 1'b1;
            end else if (imms == OS_REV16 || imms == OS_REV32 || imms == OS_REV64) begin
               if (imms == OS_REV64 && !sf) ok = 1'b0;
               else begin
                  cb = imms == OS_REV16 ? 2 : (imms == OS_REV32 ? 4 : 8);
                  for (int i = 0; i < ds / 8; i++) begin
                     pos = (i / cb) * cb + (cb - 1 - (i % cb));
                     res = res | (((a >> (8 * i)) & 64'hFF) << (8 * pos));
                  end
               end
            end else if (imms == OS_CLZ) begin
               for (int i = ds - 1; i >= 0 && !a[i]; i--) cnt++;
               res = 64'(cnt);
            end else if (imms == OS_CLS) begin
               for (int i = ds - 2; i >= 0 && a[i] == a[ds-1]; i--) cnt++;
               res = 64'(cnt);
            end else ok = 1'b0;
         end
         OP_TWO_SRC: begin
            a = read_gpr(rn, ds);
            b = read_gpr(rm, ds);
            if (w[29]) ok = 1'b0;
            else if (imms == TS_UDIV) res = b == 64'd0 ? 64'd0 : a / b;
            else if (imms == TS_SDIV) begin
               if (b != 64'd0) begin
                  // Magnitudes divide unsigned, so the overflow case wraps to the
                  // most negative value by itself.
                  q   = (a[ds-1] ? (64'd0 - a) & m : a) / (b[ds-1] ? (64'd0 - b) & m : b);
                  if (a[ds-1] != b[ds-1]) q = 64'd0 - q;
                  res = q & m;
               end
            end else if (imms == TS_LSLV || imms == TS_LSRV || imms == TS_ASRV ||
                         imms == TS_RORV)
               res = shift_by(a, imms[1:0], int'(b % 64'(ds)), ds);
            else ok = 1'b0;
         end
         OP_LOGIC_REG: begin
            if (!sf && imms[5]) ok = 1'b0;
            else begin
               a = read_gpr(rn, ds);
               b = shift_by(read_gpr(rm, ds), w[23:22], int'(imms), ds);
               if (w[21]) b = ~b & m;
               case (opc)
                  LOGIC_ORR: res = a | b;
                  LOGIC_EOR: res = a ^ b;
                  default:   res = a & b;
               endcase
               if (opc == LOGIC_ANDS) begin
                  setf = 1'b1;
                  nf   = {res[ds-1], res == 64'd0, 2'b00};
               end
            end
         end
         OP_ADDSUB_REG: begin
            if (w[23:22] == 2'd3 || (!sf && imms[5])) ok = 1'b0;
            else begin
               a = read_gpr(rn, ds);
               b = shift_by(read_gpr(rm, ds), w[23:22], int'(imms), ds);
               if (w[30]) res = sum_with_flags(a, ~b & m, 1'b1, ds, nf);
               else res = sum_with_flags(a, b, 1'b0, ds, nf);
               setf = w[29];
            end
         end
         OP_CARRY: begin
            a = read_gpr(rn, ds);
            b = read_gpr(rm, ds);
            if (w[30]) b = ~b & m;
            res  = sum_with_flags(a, b, arch_flags[1], ds, nf);
            setf = w[29];
         end
         OP_CONDSEL: begin
            if (w[29] || w[11]) ok = 1'b0;
            else begin
               a = read_gpr(rn, ds);
               b = read_gpr(rm, ds);
               if (condition_true(w[15:12], arch_flags)) res = a;
               else if (!w[30]) res = w[10] ? b + 64'd1 : b;
               else res = w[10] ? 64'd0 - b : ~b;
               res = res & m;
            end
         end
         default: ok = 1'b0;
      endcase

      if (!ok) begin
         o.nzcv      = arch_flags;
         o.undefined = 1'b1;
         return o;
      end
      res = res & m;
      if (setf) begin
         arch_flags      = nf;
         o.flags_written = 1'b1;
      end
      if (rd == ZR_INDEX && spok) begin
         arch_sp        = res;
         o.write_enable = 1'b1;
         o.dest_index   = ZR_INDEX;
         o.dest_is_sp   = 1'b1;
         o.write_value  = res;
      end else if (rd != ZR_INDEX) begin
         arch_gpr[rd]   = res;
         o.write_enable = 1'b1;
         o.dest_index   = rd;
         o.write_value  = res;
      end
      o.nzcv = arch_flags;
      return o;
   endfunction

   // A random encoding for the group; most are nudged into allocated space.
   function automatic logic [INSTR_W-1:0] random_word(input logic [OP_W-1:0] op);
      logic [INSTR_W-1:0] w;
      logic [5:0]         codes [6];
      w = $urandom;
      // Favour a few registers so that results feed later instructions.
      if ($urandom_range(0, 1)) begin
         w[4:0]   = $urandom_range(0, 4) == 0 ? ZR_INDEX : 5'($urandom_range(0, 7));
         w[9:5]   = $urandom_range(0, 4) == 0 ? ZR_INDEX : 5'($urandom_range(0, 7));
         w[20:16] = $urandom_range(0, 4) == 0 ? ZR_INDEX : 5'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 9) == 0) return w;
      case (op)
         OP_LOGIC_IMM: if (!w[31]) w[22] = 1'b0;
         OP_MOVE_WIDE: begin
            if (w[30:29] == MW_RESERVED) w[30:29] = MW_MOVK;
            if (!w[31]) w[22] = 1'b0;
         end
         OP_BITFIELD: begin
            if (w[30:29] == BF_RESERVED) w[30:29] = BF_SBFM;
            w[22] = w[31];
            if (!w[31]) begin
               w[21] = 1'b0;
               w[15] = 1'b0;
            end
         end
         OP_EXTRACT: begin
            w[30:29] = 2'd0;
            w[21]    = 1'b0;
            w[22]    = w[31];
            if (!w[31]) w[15] = 1'b0;
         end
         OP_ONE_SRC: begin
            w[29]    = 1'b0;
            w[20:16] = 5'd0;
            w[15:10] = 6'($urandom_range(0, 5));
            if (!w[31] && w[15:10] == OS_REV64) w[15:10] = OS_REV32;
         end
         OP_TWO_SRC: begin
            codes    = '{TS_UDIV, TS_SDIV, TS_LSLV, TS_LSRV, TS_ASRV, TS_RORV};
            w[29]    = 1'b0;
            // Division is slow, so it gets a smaller share.
            w[15:10] = codes[$urandom_range(0, 7) == 0 ? $urandom_range(0, 1)
                                                         : $urandom_range(2, 5)];
         end
         OP_LOGIC_REG: if (!w[31]) w[15] = 1'b0;
         OP_ADDSUB_REG: begin
            if (w[23:22] == 2'd3) w[23] = 1'b0;
            if (!w[31]) w[15] = 1'b0;
         end
         OP_CONDSEL: begin
            w[29] = 1'b0;
            w[11] = 1'b0;
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic offer_instr(input logic [OP_W-1:0] op, input logic [INSTR_W-1:0] w,
                              input bit typed, input dp_result_type typed_res);
      dp_result_type got;
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.instr_word <= w;
      do @(posedge clock); while (!req_chan.ready);
      got = execute_instr(op, w);
      pending_results.push_back(typed ? typed_res : got);
      beats_sent++;
   endtask

   // Result checker.
   always @(posedge clock) begin
      dp_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.write_enable !== want.write_enable) begin
               $error("write_enable: expected %0h, got %0h", want.write_enable,
                      rsp_chan.write_enable);
               error_count++;
            end
            if (rsp_chan.dest_index !== want.dest_index) begin
               $error("dest_index: expected %0d, got %0d", want.dest_index,
                      rsp_chan.dest_index);
               error_count++;
            end
            if (rsp_chan.dest_is_sp !== want.dest_is_sp) begin
               $error("dest_is_sp: expected %0h, got %0h", want.dest_is_sp,
                      rsp_chan.dest_is_sp);
               error_count++;
            end
            if (rsp_chan.write_value !== want.write_value) begin
               $error("write_value: expected %h, got %h", want.write_value,
                      rsp_chan.write_value);
               error_count++;
            end
            if (rsp_chan.flags_written !== want.flags_written) begin
               $error("flags_written: expected %0h, got %0h", want.flags_written,
                      rsp_chan.flags_written);
               error_count++;
            end
            if (rsp_chan.nzcv !== want.nzcv) begin
               $error("nzcv: expected %b, got %b", want.nzcv, rsp_chan.nzcv);
               error_count++;
            end
            if (rsp_chan.undefined !== want.undefined) begin
               $error("undefined: expected %0h, got %0h", want.undefined,
                      rsp_chan.undefined);
               error_count++;
            end
         end
      end
   end

   // Receiver: each time stall_count wraps, the stall style is picked at random
   // from none, random and a fixed pattern.
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      int stall_mode;
      int stall_count;
      if (stall_count == 0) stall_mode = $urandom_range(0, 2);
      stall_count = (stall_count + 1) % 64;
      if (hold_off) rsp_chan.ready <= 1'b0;
      else if (stall_mode == 0) rsp_chan.ready <= 1'b1;
      else if (stall_mode == 1) rsp_chan.ready <= $urandom_range(0, 2) != 0;
      else rsp_chan.ready <= (stall_count % 5) != 0;
   end

   // One long hold-off on the result side while instructions keep coming.
   initial begin
      wait (beats_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #4ms;
      $display("** aarch64_integer_dp_execute: FAILED **");
      $finish;
   end

   initial begin
      int              burst_left;
      logic [OP_W-1:0] op;
      req_chan.valid      = 1'b0;
      req_chan.op         = '0;
      req_chan.instr_word = '0;
      for (int i = 0; i < 31; i++) arch_gpr[i] = '0;
      arch_sp    = '0;
      arch_flags = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_instr(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                     directed_rows[i].res);

      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < RANDOM_INSTRS; n++) begin
         if ($urandom_range(0, 29) == 0)
            op = 4'($urandom_range(int'(OP_UNALLOC_FIRST), int'(OP_UNALLOC_LAST)));
         else if ($urandom_range(0, 7) == 0) op = OP_MOVE_WIDE;
         else op = 4'($urandom_range(int'(OP_ADDSUB_IMM), int'(OP_CONDSEL)));
         offer_instr(op, random_word(op), 1'b0, NO_RES);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
               req_chan.valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("** aarch64_integer_dp_execute: PASSED **");
      else $display("** aarch64_integer_dp_execute: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
